@@ sv/euler_to_quaternion_assert.svh @@
// assertion macros for the euler to quaternion block
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
// property checked on every rising clock edge outside reset
`define E2Q_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked also during reset
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ sv/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// constants and types shared by the euler to quaternion pipeline
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int TAB_LEN         = 24;
    localparam int N_ITER          = (TRIG_ITERATIONS > TAB_LEN) ? TAB_LEN : TRIG_ITERATIONS;

    localparam int ANG_W  = 17;
    localparam int Q_W    = 16;
    // half angle in degrees * 2^24 fits in 34 bits signed (|v| <= 3.02e9)
    localparam int Z_W    = 34;
    // cordic x/y in Q2.30 with growth margin
    localparam int XY_W   = 33;
    localparam int P_W    = 34;

    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 17'sd46080;
    localparam logic signed [Z_W-1:0]   DEG90  = 34'sd1509949440;
    localparam logic signed [Z_W-1:0]   DEG180 = 34'sd3019898880;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [Z_W-1:0]  z_t;

    function automatic z_t atan_val(input int i);
        logic signed [Z_W-1:0] t;
        begin
            unique case (i)
                0:  t = 34'sd754974720;
                1:  t = 34'sd445687602;
                2:  t = 34'sd235489088;
                3:  t = 34'sd119537938;
                4:  t = 34'sd60000934;
                5:  t = 34'sd30029717;
                6:  t = 34'sd15018523;
                7:  t = 34'sd7509720;
                8:  t = 34'sd3754917;
                9:  t = 34'sd1877466;
                10: t = 34'sd938734;
                11: t = 34'sd469367;
                12: t = 34'sd234684;
                13: t = 34'sd117342;
                14: t = 34'sd58671;
                15: t = 34'sd29335;
                16: t = 34'sd14668;
                17: t = 34'sd7334;
                18: t = 34'sd3667;
                19: t = 34'sd1833;
                20: t = 34'sd917;
                21: t = 34'sd458;
                22: t = 34'sd229;
                23: t = 34'sd115;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

@@ sv/euler_to_quaternion.sv @@
// throughput: one transaction per cycle unless the output stalls, set by the fully pipelined
// cordic and the two registered multiply stages
// reset: rst_n clears all valid bits asynchronously; payload is not reset
// ----------------------------------------------------------------------------
// euler_to_quaternion
// three pipelined cordic units give half-angle cos/sin, then products
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_assert.svh"
module euler_to_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // angle_x[16:0], angle_y[33:17], angle_z[50:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z, 16 bits each
);
    import e2q_pkg::*;

    localparam int NS = N_ITER + 6;

    // global enable: pipeline advances when output slot free or taken
    logic adv;
    logic [NS-1:0] vld_reg;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = vld_reg[NS-1];

    // stage 0: clamp, scale and fold
    logic neg_reg [N_ITER+1][3];
    xy_t cx_reg [N_ITER+1][3];
    xy_t cy_reg [N_ITER+1][3];
    z_t  cz_reg [N_ITER+1][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [ANG_W-1:0] a;
                z_t ang;
                logic flip;
                a = s_axis_tdata[k*ANG_W +: ANG_W];
                if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
                if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
                ang = Z_W'(a) <<< 16;
                flip = 1'b0;
                if (ang > DEG90)
                begin
                    ang = ang - DEG180;
                    flip = 1'b1;
                end
                else if (ang < -DEG90)
                begin
                    ang = ang + DEG180;
                    flip = 1'b1;
                end
                neg_reg[0][k] <= flip;
                cz_reg[0][k] <= ang;
                cx_reg[0][k] <= CORDIC_GAIN;
                cy_reg[0][k] <= '0;
            end
        end
    end

    // cordic stages, one micro-rotation each
    genvar gi;
    generate
        for (gi = 0; gi < N_ITER; gi++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        neg_reg[gi+1][k] <= neg_reg[gi][k];
                        if (!cz_reg[gi][k][Z_W-1])
                        begin
                            cx_reg[gi+1][k] <= cx_reg[gi][k] - (cy_reg[gi][k] >>> gi);
                            cy_reg[gi+1][k] <= cy_reg[gi][k] + (cx_reg[gi][k] >>> gi);
                            cz_reg[gi+1][k] <= cz_reg[gi][k] - atan_val(gi);
                        end
                        else
                        begin
                            cx_reg[gi+1][k] <= cx_reg[gi][k] + (cy_reg[gi][k] >>> gi);
                            cy_reg[gi+1][k] <= cy_reg[gi][k] - (cx_reg[gi][k] >>> gi);
                            cz_reg[gi+1][k] <= cz_reg[gi][k] + atan_val(gi);
                        end
                    end
                end
            end
        end
    endgenerate

    // sign fix, then pairwise products a*b (8 triple terms share 4 pairs)
    xy_t c_reg [3];
    xy_t s_reg [3];
    xy_t p_reg [4];   // c1c2, s1c2, c1s2, s1s2
    xy_t c3a_reg, s3a_reg;
    xy_t t_reg [8];
    logic signed [P_W+1:0] sum_reg [4];
    logic [63:0] out_reg;

    function automatic xy_t qmul(input xy_t a, input xy_t b);
        logic signed [2*XY_W-1:0] m;
        begin
            m = a * b + (66'sd1 <<< 29);
            return XY_W'(m >>> 30);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_reg[k] <= neg_reg[N_ITER][k] ? -cx_reg[N_ITER][k] : cx_reg[N_ITER][k];
                s_reg[k] <= neg_reg[N_ITER][k] ? -cy_reg[N_ITER][k] : cy_reg[N_ITER][k];
            end
            p_reg[0] <= qmul(c_reg[0], c_reg[1]);
            p_reg[1] <= qmul(s_reg[0], c_reg[1]);
            p_reg[2] <= qmul(c_reg[0], s_reg[1]);
            p_reg[3] <= qmul(s_reg[0], s_reg[1]);
            c3a_reg  <= c_reg[2];
            s3a_reg  <= s_reg[2];
            // triple products
            t_reg[0] <= qmul(p_reg[0], c3a_reg);
            t_reg[1] <= qmul(p_reg[3], s3a_reg);
            t_reg[2] <= qmul(p_reg[1], c3a_reg);
            t_reg[3] <= qmul(p_reg[2], s3a_reg);
            t_reg[4] <= qmul(p_reg[2], c3a_reg);
            t_reg[5] <= qmul(p_reg[1], s3a_reg);
            t_reg[6] <= qmul(p_reg[0], s3a_reg);
            t_reg[7] <= qmul(p_reg[3], c3a_reg);
            // component sums
            sum_reg[0] <= (P_W+2)'(t_reg[0]) - (P_W+2)'(t_reg[1]);
            sum_reg[1] <= (P_W+2)'(t_reg[2]) + (P_W+2)'(t_reg[3]);
            sum_reg[2] <= (P_W+2)'(t_reg[4]) - (P_W+2)'(t_reg[5]);
            sum_reg[3] <= (P_W+2)'(t_reg[6]) + (P_W+2)'(t_reg[7]);
            // round and saturate
            for (int k = 0; k < 4; k++)
            begin
                logic signed [P_W+1:0] r;
                r = (sum_reg[k] + (P_W+2)'(16384)) >>> 15;
                if (r > 32767)
                    out_reg[k*Q_W +: Q_W] <= 16'h7fff;
                else if (r < -32768)
                    out_reg[k*Q_W +: Q_W] <= 16'h8000;
                else
                    out_reg[k*Q_W +: Q_W] <= r[Q_W-1:0];
            end
        end
    end
    assign m_axis_tdata = out_reg;

    `E2Q_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result lost")
    `E2Q_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
    `E2Q_ASSERT(a_flow, adv && s_axis_tvalid |-> ##1 vld_reg[0], "entry valid lost")
endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// streams euler angle triples into euler_to_quaternion and checks every
// quaternion against a bit-accurate cordic and product predictor
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2q_pkg::*;

    localparam int LATENCY    = N_ITER + 6;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [15:0] qw;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
    } quat_t;

    // half-angle cosine and sine in Q2.30, built the same way the block does
    function automatic void half_angle_trig(input logic [16:0] raw,
                                            output longint c, output longint s);
        longint a, ang, x, y, z, nx;
        bit flip;
        flip = 0;
        a = longint'($signed(raw));
        if (a > 46080) a = 46080;
        if (a < -46080) a = -46080;
        ang = a * 65536;
        if (ang > longint'(DEG90)) begin
            ang -= longint'(DEG180);
            flip = 1;
        end
        else if (ang < -longint'(DEG90)) begin
            ang += longint'(DEG180);
            flip = 1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = ang;
        for (int i = 0; i < N_ITER; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(atan_val(i));
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(atan_val(i));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] round_sat_q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic quat_t euler_to_quat(logic [16:0] ax, logic [16:0] ay,
                                            logic [16:0] az);
        longint c1, s1, c2, s2, c3, s3;
        quat_t q;
        half_angle_trig(ax, c1, s1);
        half_angle_trig(ay, c2, s2);
        half_angle_trig(az, c3, s3);
        q.qw = round_sat_q15(fx_mul(fx_mul(c1, c2), c3) - fx_mul(fx_mul(s1, s2), s3));
        q.qx = round_sat_q15(fx_mul(fx_mul(s1, c2), c3) + fx_mul(fx_mul(c1, s2), s3));
        q.qy = round_sat_q15(fx_mul(fx_mul(c1, s2), c3) - fx_mul(fx_mul(s1, c2), s3));
        q.qz = round_sat_q15(fx_mul(fx_mul(c1, c2), s3) + fx_mul(fx_mul(s1, s2), c3));
        return q;
    endfunction

    // scoreboard: queue of predicted quaternions
    class quat_scoreboard;
        quat_t pending[$];
        int    n_err;
        int    n_checked;

        function void note_angles(logic [55:0] d);
            pending.insert(pending.size(), euler_to_quat(d[16:0], d[33:17], d[50:34]));
        endfunction

        function void check_quat(logic [63:0] d);
            quat_t e;
            logic [15:0] got [4];
            got[0] = d[15:0];
            got[1] = d[31:16];
            got[2] = d[47:32];
            got[3] = d[63:48];
            if (pending.size() == 0) begin
                $error("unexpected result transaction %h", d);
                n_err++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got[0] !== e.qw) begin
                $error("quat_w expected %0d actual %0d", $signed(e.qw), $signed(got[0]));
                n_err++;
            end
            if (got[1] !== e.qx) begin
                $error("quat_x expected %0d actual %0d", $signed(e.qx), $signed(got[1]));
                n_err++;
            end
            if (got[2] !== e.qy) begin
                $error("quat_y expected %0d actual %0d", $signed(e.qy), $signed(got[2]));
                n_err++;
            end
            if (got[3] !== e.qz) begin
                $error("quat_z expected %0d actual %0d", $signed(e.qz), $signed(got[3]));
                n_err++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;  // angle_x[16:0], angle_y[33:17], angle_z[50:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // quat_w, quat_x, quat_y, quat_z

    quat_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  hold_off;

    euler_to_quaternion dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // transaction monitor on both sides
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_angles(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_quat(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern plus a long hold-off on request
    initial
    begin
        int mode;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            mode = (sent / 200) % 3;
            if (hold_off)
                m_axis_tready <= 0;
            else if (mode == 0)
                m_axis_tready <= 1;
            else if (mode == 1)
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    // present one angle triple and wait for it to be taken
    task automatic send_angles(logic [16:0] ax, logic [16:0] ay, logic [16:0] az);
        s_axis_tdata  <= {5'b0, az, ay, ax};
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        s_axis_tvalid <= 0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [16:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 17'($urandom());               // any bit pattern
        if (sel == 1) return 17'(int'($urandom_range(0, 8)) * 11520 - 46080);
        return 17'($signed($urandom_range(0, 92160)) - 46080);
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        logic [16:0] edges [10];
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        idle_cycles = 0;
        sent = 0;
        hold_off = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: zero, limits, fold points, out-of-range clamp, raw extremes
        edges = '{17'sd0, 17'sd46080, -17'sd46080, 17'sd23040, -17'sd23040,
                  17'sd23041, -17'sd23041, 17'sd46081, 17'h0FFFF, 17'h10000};
        foreach (edges[i])
            send_angles(edges[i], edges[i], edges[i]);
        send_angles(17'sd11520, 17'sd0, 17'sd0);
        send_angles(17'sd0, 17'sd11520, 17'sd0);
        send_angles(17'sd0, 17'sd0, 17'sd11520);
        send_angles(17'sd46080, 17'sd0, -17'sd46080);
        send_angles(17'sd23040, 17'sd23040, 17'sd0);
        send_angles(17'h1FFFF, 17'sd1, 17'h10001);
        send_angles(17'sd45000, -17'sd30000, 17'sd12345);
        wait_drained();

        // receiver held off while sender keeps offering
        hold_off = 1;
        fork
            begin
                for (int k = 0; k < 60; k++)
                    send_angles(rand_angle(), rand_angle(), rand_angle());
            end
            begin
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
        join
        wait_drained();

        // random bursts with random gaps
        while (sent < 1450) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
                send_angles(rand_angle(), rand_angle(), rand_angle());
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
            else if ($urandom_range(0, 30) == 0) wait_drained();
        end
        s_axis_tvalid <= 0;

        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d angle triples incl. range limits, fold points and clamping;",
                 sent);
        $display("checked %0d quaternions under input gaps and output back-pressure",
                 sb.n_checked);
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/e2q_pkg.sv
sv/euler_to_quaternion.sv
sim/tb_top.sv
